FILE: sv/sdce_pkg.sv
// shared types and constants of the sieve divisor count engine
`timescale 1ns / 1ps

package sdce_pkg;

	// fixed field widths
	localparam int LIMIT_W = 16;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 12;
	localparam int PFC_W   = 4;

	// command codes
	localparam logic ACT_BUILD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// register reset and saturation limits
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [PFC_W-1:0]   PFC_MAX     = '1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_BUILT = 2'd1,
		ST_ZERO      = 2'd2
	} status_t;

	// input beat
	typedef struct packed {
		logic             action;
		logic [VAL_W-1:0] value;
	} cmd_t;

	// result beat
	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] divisor_count;
		logic [PFC_W-1:0]   prime_factor_count;
		logic [COUNT_W-1:0] composite_divisor_count;
		logic               strongly_composite;
	} result_t;

endpackage

FILE: sv/sdce_div.sv
// bit-serial restoring divider shared by all trial divisions
`timescale 1ns / 1ps

module sdce_div #(
	parameter int NW = 32,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic          rem_zero
);

	localparam int CNT_W = $clog2(NW + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;

	logic [DW:0]      trial;
	logic             fits;
	logic [DW-1:0]    rem_next;

	// one quotient bit per cycle: shift in the next dividend bit, try to subtract
	always_comb begin
		trial    = {rem_q, quo_q[NW-1]};
		fits     = trial >= {1'b0, den_q};
		rem_next = fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
	end

	// iteration control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
				den_q <= divisor;
				cnt_q <= CNT_W'(NW);
				run_q <= 1'b1;
			end else if (run_q) begin
				quo_q <= {quo_q[NW-2:0], fits};
				rem_q <= rem_next;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_zero = (rem_q == '0);

	// a new division only starts once the previous one has finished
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !run_q)
		else $error("divider restarted while running");

	// the last iteration always raises done and stops the unit
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !start && cnt_q == CNT_W'(1) |=> done_q && !run_q)
		else $error("divider did not finish after last step");

	// done is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

FILE: sv/sieve_divisor_count_engine_core.sv
// top level of the sieve divisor count engine: sequencer, prime bitmap and result register
`timescale 1ns / 1ps

// Usage
//   Command channel: an item (cmd.action, cmd.value) is taken at a clock edge where start is
//   high and busy is low. Action build sieves the odd numbers up to sieve_limit (clamped to
//   SIEVE_SIZE-1) into a one-bit prime bitmap; action query factors cmd.value by trial
//   division over the marked primes.
//   Result channel: done is high for exactly one cycle with the beat on result; the receiver
//   must take it then, there is no back-pressure.
//   Limit register: written by sieve_limit_we / sieve_limit_data; the user must write it
//   only while the block is idle; the block itself does not enforce this. A build
//   initialises the whole bitmap, one entry a cycle, then for every odd candidate i with
//   i*i <= limit reads its mark and, if set, crosses out its odd multiples. A query tests
//   every candidate p from two upward with p*p <= n, up to the end of the table, and for
//   each marked p runs trial divisions in the shared divider. Errors (no table yet, value
//   zero) are answered in the cycle after the beat is taken. One item at a time: busy
//   stays high until the result beat.
//   Reset clears the table-ready flag and sets the limit to 65535; the bitmap holds no
//   meaning until the first build.
module sieve_divisor_count_engine_core #(
	parameter int SIEVE_SIZE = 65536,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  sdce_pkg::cmd_t               cmd,
	output logic                         busy,
	input  logic                         sieve_limit_we,
	input  logic [sdce_pkg::LIMIT_W-1:0] sieve_limit_data,
	output logic                         done,
	output sdce_pkg::result_t            result
);

	localparam int AW    = $clog2(SIEVE_SIZE);
	localparam int PW    = AW + 1;
	localparam int PSQ_W = 2 * PW;
	localparam int CW    = (PSQ_W > VALUE_BITS) ? PSQ_W : VALUE_BITS;
	localparam int SV_W  = 18;
	localparam int SI_W  = 10;
	localparam int DC_W  = 16;
	localparam int PF_W  = 5;
	localparam int LW    = sdce_pkg::LIMIT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SV_TEST,
		S_SV_CHK,
		S_CROSS,
		S_Q_TEST,
		S_Q_CHK,
		S_Q_DIV,
		S_Q_FIN
	} state_t;

	state_t                    state_q;
	logic                      table_ready_q;
	logic                      done_q;
	logic                      div_start_q;
	sdce_pkg::result_t         result_q;
	logic [LW-1:0]             limit_q;
	logic [LW-1:0]             lim_q;
	logic [AW-1:0]             ctr_q;
	logic [SI_W-1:0]           i_q;
	logic [SV_W-1:0]           sq_q;
	logic [SV_W-1:0]           j_q;
	logic [VALUE_BITS-1:0]     n_q;
	logic [PW-1:0]             p_q;
	logic [PSQ_W-1:0]          psq_q;
	logic [DC_W-1:0]           divs_q;
	logic [DC_W-1:0]           base_q;
	logic [PF_W-1:0]           primes_q;
	logic                      hit_q;
	logic                      rd_bit_q;

	logic                      bitmap_mem [0:SIEVE_SIZE-1];
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic                      mem_wdata;
	logic [AW-1:0]             mem_raddr;

	logic [LW-1:0]             lim_clamp;
	logic [VALUE_BITS-1:0]     value_m;
	logic                      init_bit;
	logic [SI_W-1:0]           i_next;
	logic [SV_W-1:0]           sq_next;

	logic                      leftover;
	logic [DC_W-1:0]           fin_divs;
	logic [PF_W-1:0]           fin_primes;
	logic [DC_W-1:0]           fin_comp;
	sdce_pkg::result_t         fin_result;

	logic                      div_done;
	logic [VALUE_BITS-1:0]     div_quot;
	logic                      div_rem_zero;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sdce_pkg::LIMIT_RESET;
		end else if (sieve_limit_we) begin
			limit_q <= sieve_limit_data;
		end
	end

	// limit clamp, value width and sieve step arithmetic
	always_comb begin
		lim_clamp = (32'(limit_q) > 32'(SIEVE_SIZE - 1)) ? LW'(SIEVE_SIZE - 1) : limit_q;
		value_m   = VALUE_BITS'(cmd.value);
		init_bit  = (ctr_q == AW'(2)) ||
			(ctr_q[0] && (32'(ctr_q) >= 32'd3) && (32'(ctr_q) <= 32'(lim_q)));
		i_next    = i_q + SI_W'(2);
		// (i+2)^2 = i^2 + 4i + 4
		sq_next   = sq_q + SV_W'({i_q, 2'b00}) + SV_W'(4);
	end

	// bitmap port control
	always_comb begin
		mem_we    = (state_q == S_INIT) || (state_q == S_CROSS && j_q <= SV_W'(lim_q));
		mem_waddr = (state_q == S_INIT) ? ctr_q : AW'(j_q);
		mem_wdata = (state_q == S_INIT) ? init_bit : 1'b0;
		mem_raddr = (state_q == S_SV_TEST) ? AW'(i_q) : p_q[AW-1:0];
	end

	// prime bitmap, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_waddr] <= mem_wdata;
		end
		rd_bit_q <= bitmap_mem[mem_raddr];
	end

	// shared trial divider
	sdce_div #(
		.NW(VALUE_BITS),
		.DW(PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (n_q),
		.divisor  (p_q),
		.done     (div_done),
		.quotient (div_quot),
		.rem_zero (div_rem_zero)
	);

	// final counts, a cofactor above one counts as one more prime
	always_comb begin
		leftover   = n_q > VALUE_BITS'(1);
		fin_divs   = divs_q + (leftover ? divs_q : '0);
		fin_primes = primes_q + PF_W'(leftover);
		fin_comp   = fin_divs - DC_W'(fin_primes) - DC_W'(1);
		fin_result.status = sdce_pkg::ST_OK;
		fin_result.divisor_count = (fin_divs > DC_W'(sdce_pkg::COUNT_MAX)) ?
			sdce_pkg::COUNT_MAX : fin_divs[sdce_pkg::COUNT_W-1:0];
		fin_result.prime_factor_count = (fin_primes > PF_W'(sdce_pkg::PFC_MAX)) ?
			sdce_pkg::PFC_MAX : fin_primes[sdce_pkg::PFC_W-1:0];
		fin_result.composite_divisor_count = (fin_comp > DC_W'(sdce_pkg::COUNT_MAX)) ?
			sdce_pkg::COUNT_MAX : fin_comp[sdce_pkg::COUNT_W-1:0];
		fin_result.strongly_composite = fin_comp > DC_W'(fin_primes);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			table_ready_q <= 1'b0;
			done_q        <= 1'b0;
			div_start_q   <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.action == sdce_pkg::ACT_BUILD) begin
							lim_q   <= lim_clamp;
							ctr_q   <= '0;
							state_q <= S_INIT;
						end else if (!table_ready_q) begin
							result_q <= '{status: sdce_pkg::ST_NOT_BUILT, default: '0};
							done_q   <= 1'b1;
						end else if (value_m == '0) begin
							result_q <= '{status: sdce_pkg::ST_ZERO, default: '0};
							done_q   <= 1'b1;
						end else begin
							n_q      <= value_m;
							p_q      <= PW'(2);
							psq_q    <= PSQ_W'(4);
							divs_q   <= DC_W'(1);
							primes_q <= '0;
							state_q  <= S_Q_TEST;
						end
					end
				end
				// sweep the whole bitmap: odd candidates up to the limit, and two
				S_INIT: begin
					if (ctr_q == AW'(SIEVE_SIZE - 1)) begin
						i_q     <= SI_W'(3);
						sq_q    <= SV_W'(9);
						state_q <= S_SV_TEST;
					end else begin
						ctr_q <= ctr_q + 1'b1;
					end
				end
				// stop once i*i passes the limit, else read the mark of i
				S_SV_TEST: begin
					if (sq_q > SV_W'(lim_q)) begin
						table_ready_q <= 1'b1;
						result_q      <= '0;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_SV_CHK;
					end
				end
				S_SV_CHK: begin
					if (rd_bit_q) begin
						j_q     <= sq_q;
						state_q <= S_CROSS;
					end else begin
						i_q     <= i_next;
						sq_q    <= sq_next;
						state_q <= S_SV_TEST;
					end
				end
				// cross out odd multiples from i*i in steps of 2i
				S_CROSS: begin
					if (j_q <= SV_W'(lim_q)) begin
						j_q <= j_q + SV_W'({i_q, 1'b0});
					end else begin
						i_q     <= i_next;
						sq_q    <= sq_next;
						state_q <= S_SV_TEST;
					end
				end
				// candidate loop ends when p*p passes n or the table runs out
				S_Q_TEST: begin
					if (p_q == PW'(SIEVE_SIZE) || CW'(psq_q) > CW'(n_q)) begin
						state_q <= S_Q_FIN;
					end else begin
						state_q <= S_Q_CHK;
					end
				end
				S_Q_CHK: begin
					if (rd_bit_q) begin
						div_start_q <= 1'b1;
						base_q      <= divs_q;
						hit_q       <= 1'b0;
						state_q     <= S_Q_DIV;
					end else begin
						p_q     <= p_q + 1'b1;
						psq_q   <= psq_q + PSQ_W'({p_q, 1'b1});
						state_q <= S_Q_TEST;
					end
				end
				// divide out p while it goes; each hit adds one more multiple of the old count
				S_Q_DIV: begin
					if (div_done) begin
						if (div_rem_zero) begin
							n_q         <= div_quot;
							divs_q      <= divs_q + base_q;
							hit_q       <= 1'b1;
							div_start_q <= 1'b1;
							if (!hit_q) begin
								primes_q <= primes_q + 1'b1;
							end
						end else begin
							p_q     <= p_q + 1'b1;
							psq_q   <= psq_q + PSQ_W'({p_q, 1'b1});
							state_q <= S_Q_TEST;
						end
					end
				end
				S_Q_FIN: begin
					result_q <= fin_result;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// a build beat always takes the block out of idle
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == sdce_pkg::ACT_BUILD |=> busy)
		else $error("build beat did not start the sequencer");

	// the bitmap is only written while a build runs
	a_write_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INIT || state_q == S_CROSS))
		else $error("bitmap written outside a build");

	// a query before any build is answered at once with the not-built status
	a_not_built: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.action == sdce_pkg::ACT_QUERY && !table_ready_q
		|=> done && result.status == sdce_pkg::ST_NOT_BUILT)
		else $error("query before build not rejected");

endmodule
